// ===== design/gbam_pkg.sv =====
// Shared types, constants and functions of the gray block average ASCII mapper.
// Used by every module of the block; depends on nothing else.
package gbam_pkg;

   localparam int BLOCK_W = 4;
   localparam int BLOCK_H = 5;

   localparam int CSR_DATA_W = 13;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam int HEIGHT_MIN = 5;
   localparam int HEIGHT_MAX = 4096;
   localparam int WIDTH_MIN = 4;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_WIDTH = 640;

   localparam int ROW_W = 12;
   localparam int HEIGHT_W = 13;
   localparam int BROW_W = 10;
   localparam int RIB_W = 3;
   localparam logic [RIB_W-1:0] RIB_LAST = 3'd4;

   localparam int WSUM_W = 15;
   localparam int SUM_W = 13;
   localparam int GRAY_W = 8;
   localparam int GLYPH_W = 7;

   // Reciprocal constants: x/100 for x < 2^15, x/20 and x/5 for x < 2^14.
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int RECIP_100_SHIFT = 19;
   localparam logic [11:0] RECIP_20 = 12'd3277;
   localparam int RECIP_20_SHIFT = 16;
   localparam logic [13:0] RECIP_5 = 14'd13108;
   localparam int RECIP_5_SHIFT = 16;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   localparam logic [7:0] LEVEL_LIMITS [9] = '{8'd26, 8'd51, 8'd77, 8'd102, 8'd128,
                                              8'd153, 8'd179, 8'd204, 8'd230};
   localparam logic [6:0] GLYPH_CODES [10] = '{7'd32, 7'd46, 7'd44, 7'd58, 7'd59,
                                              7'd111, 7'd120, 7'd36, 7'd35, 7'd64};

   typedef struct packed {
      logic start;
      logic fin;
      logic last_row;
      logic last_frame;
   } blk_tag_type;

   typedef struct packed {
      logic                last_frame;
      logic                last_row;
      logic [GRAY_W-1:0]   gray_level;
      logic [GLYPH_W-1:0]  glyph;
   } result_type;

   function automatic logic [GLYPH_W-1:0] pick_glyph(input logic [GRAY_W-1:0] level);
      logic [3:0] k;
      k = '0;
      for (int i = 0; i < 9; i++) begin
         if (level >= LEVEL_LIMITS[i]) begin
            k = 4'(i + 1);
         end
      end
      return GLYPH_CODES[k];
   endfunction

endpackage

// ===== design/gbam_ctrl.sv =====
// Frame geometry registers and the raster position counters.
// Marks each pixel with its block column and block position; uses gbam_pkg.
module gbam_ctrl #(
   parameter int MAX_WIDTH = 2048,
   parameter int CW = $clog2(MAX_WIDTH),
   parameter int BW = (CW > 2) ? CW - 2 : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [gbam_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gbam_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                accept,
   output logic                                hit,
   output logic [BW-1:0]                       blk,
   output gbam_pkg::blk_tag_type               tag
);
   import gbam_pkg::*;

   localparam int WW = CW + 1;
   localparam int RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   logic [WW-1:0]       width_ff, width_in;
   logic [WW-3:0]       bcols_ff, bcols_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [BROW_W-1:0]   brows_ff, brows_in;

   logic [CW-1:0]       col_ff, col_in;
   logic [RIB_W-1:0]    rib_ff, rib_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [BROW_W-1:0]   brow_ff, brow_in;

   logic [13:0]         w_ext, w_cl;
   logic [HEIGHT_W-1:0] h_raw, h_cl;
   logic [26:0]         h_prod;
   logic [WW-1:0]       col_inc, blk_ext, bcols_ext;
   logic [HEIGHT_W-1:0] row_inc;
   logic [1:0]          sub;

   always_comb begin
      w_ext = 14'(csr_data[11:0]);
      if (w_ext < 14'(WIDTH_MIN)) begin
         w_cl = 14'(WIDTH_MIN);
      end else if (w_ext > 14'(MAX_WIDTH)) begin
         w_cl = 14'(MAX_WIDTH);
      end else begin
         w_cl = w_ext;
      end
      h_raw = csr_data[HEIGHT_W-1:0];
      if (h_raw < HEIGHT_W'(HEIGHT_MIN)) begin
         h_cl = HEIGHT_W'(HEIGHT_MIN);
      end else if (h_raw > HEIGHT_W'(HEIGHT_MAX)) begin
         h_cl = HEIGHT_W'(HEIGHT_MAX);
      end else begin
         h_cl = h_raw;
      end
      h_prod = 27'(h_cl) * 27'(RECIP_5);

      width_in = width_ff;
      bcols_in = bcols_ff;
      height_in = height_ff;
      brows_in = brows_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_in = WW'(w_cl);
               bcols_in = (WW-2)'(w_cl >> 2);
            end
            REG_IMAGE_HEIGHT: begin
               height_in = h_cl;
               brows_in = BROW_W'(h_prod >> RECIP_5_SHIFT);
            end
         endcase
      end
   end

   always_comb begin
      col_inc = WW'(col_ff) + WW'(1);
      row_inc = HEIGHT_W'(row_ff) + HEIGHT_W'(1);
      sub = col_ff[1:0];
      blk = BW'(col_ff >> 2);
      blk_ext = WW'(blk);
      bcols_ext = WW'(bcols_ff);
      hit = (blk_ext < bcols_ext) && (brow_ff < brows_ff);
      tag.start = (rib_ff == '0) && (sub == 2'd0);
      tag.fin = (rib_ff == RIB_LAST) && (sub == 2'd3);
      tag.last_row = (blk_ext + WW'(1)) == bcols_ext;
      tag.last_frame = tag.last_row && ((brow_ff + BROW_W'(1)) == brows_ff);

      col_in = col_ff;
      rib_in = rib_ff;
      row_in = row_ff;
      brow_in = brow_ff;
      if (accept) begin
         if (col_inc >= width_ff) begin
            col_in = '0;
            if (row_inc >= height_ff) begin
               row_in = '0;
               rib_in = '0;
               brow_in = '0;
            end else begin
               row_in = ROW_W'(row_inc);
               if (rib_ff >= RIB_LAST) begin
                  rib_in = '0;
                  brow_in = brow_ff + BROW_W'(1);
               end else begin
                  rib_in = rib_ff + RIB_W'(1);
               end
            end
         end else begin
            col_in = CW'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WW'(RESET_W);
         bcols_ff <= (WW-2)'(RESET_W / 4);
         height_ff <= HEIGHT_W'(RESET_HEIGHT);
         brows_ff <= BROW_W'(RESET_HEIGHT / 5);
         col_ff <= '0;
         rib_ff <= '0;
         row_ff <= '0;
         brow_ff <= '0;
      end else begin
         width_ff <= width_in;
         bcols_ff <= bcols_in;
         height_ff <= height_in;
         brows_ff <= brows_in;
         col_ff <= col_in;
         rib_ff <= rib_in;
         row_ff <= row_in;
         brow_ff <= brow_in;
      end
   end

endmodule

// ===== design/gbam_accum.sv =====
// Gray conversion and the block sum memory with its read, add and write back.
// Forwards the last written sum to a following pixel of the same block; uses gbam_pkg.
module gbam_accum #(
   parameter int MAX_WIDTH = 2048,
   parameter int BW = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [7:0]                    in_red,
   input  logic [7:0]                    in_green,
   input  logic [7:0]                    in_blue,
   input  logic [BW-1:0]                 in_blk,
   input  gbam_pkg::blk_tag_type         in_tag,
   output logic                          res_valid,
   output logic [gbam_pkg::SUM_W-1:0]    res_sum,
   output gbam_pkg::blk_tag_type         res_tag,
   output logic [1:0]                    pend
);
   import gbam_pkg::*;

   localparam int NB = MAX_WIDTH / 4;

   logic [SUM_W-1:0]  sums_mem [NB];

   logic              s1_v_ff;
   logic [WSUM_W-1:0] s1_wsum_ff, s1_wsum_in;
   logic [BW-1:0]     s1_blk_ff;
   blk_tag_type       s1_tag_ff;

   logic              s2_v_ff;
   logic [GRAY_W-1:0] s2_gray_ff, s2_gray_in;
   logic [BW-1:0]     s2_blk_ff;
   blk_tag_type       s2_tag_ff;
   logic [SUM_W-1:0]  rd_data_ff;

   logic              fwd_v_ff;
   logic [BW-1:0]     fwd_blk_ff;
   logic [SUM_W-1:0]  fwd_sum_ff;

   logic              res_v_ff;
   logic [SUM_W-1:0]  res_sum_ff, sum_in;
   blk_tag_type       res_tag_ff;

   logic [27:0]       gray_prod;
   logic [SUM_W-1:0]  base;

   always_comb begin
      s1_wsum_in = WSUM_W'(in_red) * WSUM_W'(30) + WSUM_W'(in_green) * WSUM_W'(59)
                 + WSUM_W'(in_blue) * WSUM_W'(11);
      gray_prod = 28'(s1_wsum_ff) * 28'(RECIP_100);
      s2_gray_in = GRAY_W'(gray_prod >> RECIP_100_SHIFT);
      base = (fwd_v_ff && (fwd_blk_ff == s2_blk_ff)) ? fwd_sum_ff : rd_data_ff;
      sum_in = s2_tag_ff.start ? SUM_W'(s2_gray_ff) : base + SUM_W'(s2_gray_ff);
      pend = 2'(s1_v_ff && s1_tag_ff.fin) + 2'(s2_v_ff && s2_tag_ff.fin) + 2'(res_v_ff);
      res_valid = res_v_ff;
      res_sum = res_sum_ff;
      res_tag = res_tag_ff;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= sums_mem[s1_blk_ff];
      if (s2_v_ff) begin
         sums_mem[s2_blk_ff] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         fwd_v_ff <= 1'b0;
         res_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         fwd_v_ff <= s2_v_ff;
         res_v_ff <= s2_v_ff && s2_tag_ff.fin;
      end
      s1_wsum_ff <= s1_wsum_in;
      s1_blk_ff <= in_blk;
      s1_tag_ff <= in_tag;
      s2_gray_ff <= s2_gray_in;
      s2_blk_ff <= s1_blk_ff;
      s2_tag_ff <= s1_tag_ff;
      fwd_blk_ff <= s2_blk_ff;
      fwd_sum_ff <= sum_in;
      res_sum_ff <= sum_in;
      res_tag_ff <= s2_tag_ff;
   end

endmodule

// ===== design/gbam_out.sv =====
// Block average, glyph selection and the result queue in front of the output port.
// Takes finished block sums from gbam_accum; uses gbam_pkg.
module gbam_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  logic [gbam_pkg::SUM_W-1:0]    res_sum,
   input  gbam_pkg::blk_tag_type         res_tag,
   input  logic                          pop,
   output logic                          out_valid,
   output gbam_pkg::result_type          out_data,
   output logic [gbam_pkg::FIFO_CNT_W-1:0] busy
);
   import gbam_pkg::*;

   result_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;

   logic                  avg_v_ff;
   logic [GRAY_W-1:0]     avg_ff, avg_in;
   logic                  avg_lr_ff;
   logic                  avg_lf_ff;

   logic [24:0]           avg_prod;
   logic [8:0]            avg_full;
   result_type            push_data;
   logic                  do_pop;

   always_comb begin
      avg_prod = 25'(res_sum) * 25'(RECIP_20);
      avg_full = 9'(avg_prod >> RECIP_20_SHIFT);
      avg_in = (avg_full > 9'd255) ? 8'd255 : avg_full[7:0];
      push_data.last_frame = avg_lf_ff;
      push_data.last_row = avg_lr_ff;
      push_data.gray_level = avg_ff;
      push_data.glyph = pick_glyph(avg_ff);
      out_valid = cnt_ff != '0;
      out_data = fifo_ff[rd_ptr_ff];
      do_pop = pop && out_valid;
      cnt_in = cnt_ff + FIFO_CNT_W'(avg_v_ff) - FIFO_CNT_W'(do_pop);
      busy = cnt_ff + FIFO_CNT_W'(avg_v_ff);
   end

   always_ff @(posedge clock) begin
      if (avg_v_ff) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
      avg_ff <= avg_in;
      avg_lr_ff <= res_tag.last_row;
      avg_lf_ff <= res_tag.last_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_v_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         avg_v_ff <= res_valid;
         if (avg_v_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/gray_block_average_ascii_mapper_unit.sv =====
// A block's result passes the sum, gray, block sum and average registers into the rsp queue.
// Throughput: one pixel per cycle; req_tready drops only while eight results are queued or
// in flight, which the eight-entry result queue sets.
// Reset: counters cleared, geometry back to 640 x 480; the block sum memory is not cleared,
// each block's first pixel overwrites its entry.
module gray_block_average_ascii_mapper_unit #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // glyph[6:0], gray_level[14:7], zero[15]
   output logic        rsp_tlast,   // last_in_row
   output logic        rsp_tuser,   // last_in_frame
   input  logic        csr_we,
   input  logic [gbam_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbam_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gbam_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int BW = (CW > 2) ? CW - 2 : 1;

   logic                  accept;
   logic                  hit;
   logic [BW-1:0]         blk;
   blk_tag_type           tag;
   logic                  res_valid;
   logic [SUM_W-1:0]      res_sum;
   blk_tag_type           res_tag;
   logic [1:0]            pend;
   logic [FIFO_CNT_W-1:0] busy;
   logic [FIFO_CNT_W:0]   occupied;
   result_type            out_data;

   always_comb begin
      occupied = (FIFO_CNT_W+1)'(busy) + (FIFO_CNT_W+1)'(pend);
      req_tready = occupied < (FIFO_CNT_W+1)'(FIFO_DEPTH);
      accept = req_tvalid && req_tready;
      rsp_tdata = {1'b0, out_data.gray_level, out_data.glyph};
      rsp_tlast = out_data.last_row;
      rsp_tuser = out_data.last_frame;
   end

   gbam_ctrl #(
      .MAX_WIDTH(MAX_WIDTH),
      .CW(CW),
      .BW(BW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .accept(accept),
      .hit(hit),
      .blk(blk),
      .tag(tag)
   );

   gbam_accum #(
      .MAX_WIDTH(MAX_WIDTH),
      .BW(BW)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .in_valid(accept && hit),
      .in_red(req_tdata[7:0]),
      .in_green(req_tdata[15:8]),
      .in_blue(req_tdata[23:16]),
      .in_blk(blk),
      .in_tag(tag),
      .res_valid(res_valid),
      .res_sum(res_sum),
      .res_tag(res_tag),
      .pend(pend)
   );

   gbam_out u_out (
      .clock(clock),
      .reset(reset),
      .res_valid(res_valid),
      .res_sum(res_sum),
      .res_tag(res_tag),
      .pop(rsp_tready),
      .out_valid(rsp_tvalid),
      .out_data(out_data),
      .busy(busy)
   );

endmodule

// ===== dv/gbam_checker.sv =====
`timescale 1ns / 100ps
// Checker for the gray block average ASCII mapper: watches the pixel, result and register
// ports, predicts each block result and compares it. Depends on gbam_pkg.
module gbam_checker #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [23:0]                      req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [15:0]                      rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [gbam_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbam_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               error_count,
   output int                               outstanding
);
   import gbam_pkg::*;

   localparam int BLOCK_SLOTS = MAX_WIDTH / BLOCK_W;
   localparam int BLOCK_AREA = BLOCK_W * BLOCK_H;
   localparam logic [7:0] TONE_STEPS [9] = '{8'd26, 8'd51, 8'd77, 8'd102, 8'd128,
                                            8'd153, 8'd179, 8'd204, 8'd230};
   localparam logic [7:0] GLYPH_SET [10] = '{" ", ".", ",", ":", ";",
                                           "o", "x", "$", "#", "@"};

   typedef struct packed {
      logic [6:0] glyph;
      logic [7:0] level;
      logic       row_end;
      logic       frame_end;
   } block_result_type;

   logic [11:0]      width_reg;
   logic [12:0]      height_reg;
   logic [12:0]      block_sum [BLOCK_SLOTS];
   int unsigned      column;
   int unsigned      row_in_block;
   int unsigned      row;
   block_result_type block_results_q[$];
   int               mismatches = 0;

   function automatic logic [6:0] glyph_for(input logic [7:0] level);
      int k;
      k = 0;
      while (k < 9 && level >= TONE_STEPS[k]) k++;
      return GLYPH_SET[k][6:0];
   endfunction

   function automatic int unsigned luma(input logic [23:0] px);
      return (30 * px[7:0] + 59 * px[15:8] + 11 * px[23:16]) / 100;
   endfunction

   task automatic accumulate_pixel(input logic [23:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      cols;
      int unsigned      whole_rows;
      int unsigned      blk;
      int unsigned      sub;
      int unsigned      avg;
      block_result_type res;
      w = width_reg;
      if (w < WIDTH_MIN) w = WIDTH_MIN;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < HEIGHT_MIN) h = HEIGHT_MIN;
      if (h > HEIGHT_MAX) h = HEIGHT_MAX;
      cols = w / BLOCK_W;
      whole_rows = h / BLOCK_H;
      if (column < cols * BLOCK_W && row < whole_rows * BLOCK_H) begin
         blk = column / BLOCK_W;
         sub = column % BLOCK_W;
         if (row_in_block == 0 && sub == 0) begin
            block_sum[blk] = 13'(luma(px));
         end else begin
            block_sum[blk] = block_sum[blk] + 13'(luma(px));
         end
         if (row_in_block == BLOCK_H - 1 && sub == BLOCK_W - 1) begin
            avg = block_sum[blk] / BLOCK_AREA;
            if (avg > 255) avg = 255;
            res.level = 8'(avg);
            res.glyph = glyph_for(res.level);
            res.row_end = (blk == cols - 1);
            res.frame_end = res.row_end && (row / BLOCK_H == whole_rows - 1);
            block_results_q.push_back(res);
         end
      end
      column++;
      if (column >= w) begin
         column = 0;
         row++;
         row_in_block++;
         if (row_in_block >= BLOCK_H) row_in_block = 0;
         if (row >= h) begin
            row = 0;
            row_in_block = 0;
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      block_result_type got;
      block_result_type want;
      if (reset) begin
         width_reg = 12'(RESET_WIDTH);
         height_reg = 13'(RESET_HEIGHT);
         column = 0;
         row_in_block = 0;
         row = 0;
         block_results_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_IMAGE_WIDTH) begin
               width_reg = csr_data[11:0];
            end else if (csr_index == REG_IMAGE_HEIGHT) begin
               height_reg = csr_data;
            end
         end
         if (req_tvalid && req_tready) accumulate_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.glyph = rsp_tdata[6:0];
            got.level = rsp_tdata[14:7];
            got.row_end = rsp_tlast;
            got.frame_end = rsp_tuser;
            if (block_results_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: unexpected block result: glyph %0d level %0d %s %0b %s %0b",
                           $realtime, got.glyph, got.level, "row_end", got.row_end,
                           "frame_end", got.frame_end);
               end
               mismatches++;
            end else begin
               want = block_results_q.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("%0t: block result mismatch: expected glyph %0d level %0d %s",
                              $realtime, want.glyph, want.level, "row_end/frame_end");
                     $display("%0t:    expected row_end %0b frame_end %0b",
                              $realtime, want.row_end, want.frame_end);
                     $display("%0t:    actual   glyph %0d level %0d row_end %0b frame_end %0b",
                              $realtime, got.glyph, got.level, got.row_end, got.frame_end);
                  end
                  mismatches++;
               end
            end
         end
      end
      error_count <= mismatches;
      outstanding <= block_results_q.size();
   end

endmodule

// ===== dv/tb_gray_block_average_ascii_mapper_unit.sv =====
`timescale 1ns / 100ps
// Top of the mapper testbench: clock, reset, pixel and register stimulus, result-side stalls
// and the verdict. Depends on gbam_pkg, the mapper unit and gbam_checker.
module tb_gray_block_average_ascii_mapper_unit;
   import gbam_pkg::*;

   localparam int MAX_W = 2048;
   localparam int RANDOM_PIXELS = 720;
   localparam logic [23:0] FIRST_PIXELS [25] = '{
      24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
      24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FFFF, 24'hFFFF00,
      24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE, 24'h000000,
      24'h555555, 24'hAAAAAA, 24'h123456, 24'hEDCBA9, 24'hFFFFFF,
      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000
   };

   typedef enum int {
      PACE_FULL,
      PACE_SENDER_GAPS,
      PACE_SINK_STALLS,
      PACE_BOTH_LIGHT
   } pace_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // red[7:0], green[15:8], blue[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;    // glyph[6:0], gray_level[14:7], zero[15]
   logic        rsp_tlast;    // last_in_row
   logic        rsp_tuser;    // last_in_frame
   logic        csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int error_count;
   int outstanding;
   int idle_pct = 0;
   int stall_pct = 0;
   int row_pos = 0;
   int row_in_group = 0;
   int random_sent = 0;
   logic [7:0] tones [MAX_W / BLOCK_W];

   always #10 clock = ~clock;

   gray_block_average_ascii_mapper_unit #(
      .MAX_WIDTH(MAX_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   gbam_checker #(
      .MAX_WIDTH(MAX_W)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .error_count(error_count),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [7:0] pick_tone();
      unique case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [23:0] shade(input logic [7:0] tone);
      logic [23:0] px;
      int          v;
      if ($urandom_range(7) == 0) return 24'($urandom);
      for (int ch = 0; ch < 3; ch++) begin
         v = int'(tone) + int'($urandom_range(16)) - 8;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         px[ch * 8 +: 8] = 8'(v);
      end
      return px;
   endfunction

   task automatic send_pixel(input logic [23:0] px);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_geometry(input logic [12:0] width_word,
                                   input logic [12:0] height_word);
      csr_we <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_data <= width_word;
      @(posedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_data <= height_word;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_row(input int w_use, input int h_use);
      if (row_in_group == 0) begin
         for (int k = 0; k < w_use / BLOCK_W; k++) tones[k] = pick_tone();
      end
      for (int c = 0; c < w_use; c++) begin
         if ($urandom_range(199) == 0) wait_drained();
         send_pixel(shade(tones[c / BLOCK_W]));
         random_sent++;
      end
      row_pos++;
      row_in_group = (row_in_group == BLOCK_H - 1) ? 0 : row_in_group + 1;
      if (row_pos >= h_use) begin
         row_pos = 0;
         row_in_group = 0;
      end
   endtask

   // Geometry changes only at the top of a block row, so every block that completes
   // afterwards has had its first pixel seen under the new geometry.
   task automatic run_phase(input logic [12:0] width_word, input logic [12:0] height_word,
                            input int min_rows, input bit whole_frame, input pace_type pace);
      int w_use;
      int h_use;
      int done;
      program_geometry(width_word, height_word);
      w_use = int'(width_word[11:0]);
      if (w_use < WIDTH_MIN) w_use = WIDTH_MIN;
      if (w_use > MAX_W) w_use = MAX_W;
      h_use = int'(height_word);
      if (h_use < HEIGHT_MIN) h_use = HEIGHT_MIN;
      if (h_use > HEIGHT_MAX) h_use = HEIGHT_MAX;
      unique case (pace)
         PACE_FULL: begin
            idle_pct = 0;
            stall_pct = 0;
         end
         PACE_SENDER_GAPS: begin
            idle_pct = 55;
            stall_pct = 0;
         end
         PACE_SINK_STALLS: begin
            idle_pct = 0;
            stall_pct = 55;
         end
         default: begin
            idle_pct = 7;
            stall_pct = 7;
         end
      endcase
      done = 0;
      while (done < min_rows || row_in_group != 0 || (whole_frame && row_pos != 0)) begin
         send_row(w_use, h_use);
         done++;
      end
      wait_drained();
   endtask

   initial begin
      logic [12:0] width_word;
      logic [12:0] height_word;
      int          phase_no;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One 5 x 5 frame: a single block plus an ignored fifth column.
      program_geometry(13'd5, 13'd5);
      foreach (FIRST_PIXELS[i]) send_pixel(FIRST_PIXELS[i]);
      wait_drained();

      // Narrowest rows in the tallest frame; both sizes saturate.
      run_phase(13'd0, 13'h1FFF, 1, 1'b0, PACE_SINK_STALLS);

      random_sent = 0;
      phase_no = 0;
      while (random_sent < RANDOM_PIXELS) begin
         width_word = ($urandom_range(7) == 0) ? 13'($urandom_range(3))
                                               : 13'($urandom_range(4, 28));
         width_word[12] = 1'($urandom_range(1));
         height_word = ($urandom_range(7) == 0) ? 13'($urandom_range(4))
                                                : 13'($urandom_range(5, 23));
         run_phase(width_word, height_word, $urandom_range(5, 15), 1'b0,
                   pace_type'(phase_no % 4));
         phase_no++;
      end

      wait_drained();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
